### rtl/core/acfp_pkg.sv
`timescale 1ns / 1ps

package acfp_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_L      = 8'h4C;
  localparam logic [7:0] CHAR_O      = 8'h4F;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef struct packed {
    logic [COORD_W-1:0] x_value;
    logic [COORD_W-1:0] y_value;
    logic               target_lost;
    logic [FRAME_W-1:0] frame_number;
  } result_t;

  // Expected character of the LOST keyword at body positions 0 to 3.
  function automatic logic [7:0] lost_char(input logic [1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      2'd0: ch = CHAR_L;
      2'd1: ch = CHAR_O;
      2'd2: ch = CHAR_S;
      default: ch = CHAR_T;
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  endfunction

  // acc * 10 + digit, wrapping at 16 bits.
  function automatic logic [COORD_W-1:0] dec_step(input logic [COORD_W-1:0] acc,
                                                  input logic [7:0] ch);
    logic [7:0] d;
    d = ch - CHAR_ZERO;
    return (acc << 3) + (acc << 1) + {{(COORD_W-4){1'b0}}, d[3:0]};
  endfunction

endpackage

### rtl/core/acfp_parser.sv
`timescale 1ns / 1ps

module acfp_parser #(
  parameter int unsigned BODY_BUFFER_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output acfp_pkg::result_t res
);
  import acfp_pkg::*;

  localparam int unsigned CNT_W = $clog2(BODY_BUFFER_SIZE);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BODY_BUFFER_SIZE - 1);

  logic               in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               lost_r, lost_nxt;
  logic               comma_seen_r, comma_seen_nxt;
  logic [CNT_W-1:0]   comma_pos_r, comma_pos_nxt;
  logic [COORD_W-1:0] x_acc_r, x_acc_nxt;
  logic               x_neg_r, x_neg_nxt;
  logic               x_end_r, x_end_nxt;
  logic [COORD_W-1:0] y_acc_r, y_acc_nxt;
  logic               y_neg_r, y_neg_nxt;
  logic               y_end_r, y_end_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  logic               coord_ok;
  logic               y_first;

  assign coord_ok = comma_seen_r && (comma_pos_r != '0) &&
                    (({1'b0, comma_pos_r} + {{CNT_W{1'b0}}, 1'b1}) < {1'b0, count_r});
  assign y_first  = (count_r == comma_pos_r + CNT_W'(1));

  always_comb begin
    in_frame_nxt   = in_frame_r;
    count_nxt      = count_r;
    lost_nxt       = lost_r;
    comma_seen_nxt = comma_seen_r;
    comma_pos_nxt  = comma_pos_r;
    x_acc_nxt      = x_acc_r;
    x_neg_nxt      = x_neg_r;
    x_end_nxt      = x_end_r;
    y_acc_nxt      = y_acc_r;
    y_neg_nxt      = y_neg_r;
    y_end_nxt      = y_end_r;
    frame_nxt      = frame_r;
    res_valid      = 1'b0;
    res            = '0;

    if (!in_frame_r) begin
      if (rx_byte == CHAR_DOLLAR) begin
        in_frame_nxt = 1'b1;
      end
    end else if ((rx_byte == CHAR_CR) || (rx_byte == CHAR_LF)) begin
      in_frame_nxt = 1'b0;
      // The LOST keyword wins over any comma that follows it.
      if ((count_r >= CNT_W'(4)) && lost_r) begin
        frame_nxt        = frame_r + FRAME_W'(1);
        res_valid        = step_en;
        res.target_lost  = 1'b1;
        res.frame_number = frame_nxt;
      end else if (coord_ok) begin
        frame_nxt        = frame_r + FRAME_W'(1);
        res_valid        = step_en;
        res.x_value      = x_neg_r ? (COORD_W'(0) - x_acc_r) : x_acc_r;
        res.y_value      = y_neg_r ? (COORD_W'(0) - y_acc_r) : y_acc_r;
        res.frame_number = frame_nxt;
      end
    end else if (count_r >= CNT_LIMIT) begin
      in_frame_nxt = 1'b0;
    end else begin
      if ((count_r < CNT_W'(4)) && (rx_byte != lost_char(count_r[1:0]))) begin
        lost_nxt = 1'b0;
      end
      if (!comma_seen_r) begin
        if (rx_byte == CHAR_COMMA) begin
          comma_seen_nxt = 1'b1;
          comma_pos_nxt  = count_r;
          x_end_nxt      = 1'b1;
        end else if ((count_r == '0) && (rx_byte == CHAR_MINUS)) begin
          x_neg_nxt = 1'b1;
        end else if (!x_end_r && is_digit(rx_byte)) begin
          x_acc_nxt = dec_step(x_acc_r, rx_byte);
        end else begin
          x_end_nxt = 1'b1;
        end
      end else begin
        if (y_first && (rx_byte == CHAR_MINUS)) begin
          y_neg_nxt = 1'b1;
        end else if (!y_end_r && is_digit(rx_byte)) begin
          y_acc_nxt = dec_step(y_acc_r, rx_byte);
        end else begin
          y_end_nxt = 1'b1;
        end
      end
      count_nxt = count_r + CNT_W'(1);
    end

    // Any change of framing starts the next body from a clean slate.
    if (in_frame_nxt != in_frame_r) begin
      count_nxt      = '0;
      lost_nxt       = 1'b1;
      comma_seen_nxt = 1'b0;
      comma_pos_nxt  = '0;
      x_acc_nxt      = '0;
      x_neg_nxt      = 1'b0;
      x_end_nxt      = 1'b0;
      y_acc_nxt      = '0;
      y_neg_nxt      = 1'b0;
      y_end_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      count_r      <= '0;
      lost_r       <= 1'b1;
      comma_seen_r <= 1'b0;
      comma_pos_r  <= '0;
      x_acc_r      <= '0;
      x_neg_r      <= 1'b0;
      x_end_r      <= 1'b0;
      y_acc_r      <= '0;
      y_neg_r      <= 1'b0;
      y_end_r      <= 1'b0;
      frame_r      <= '0;
    end else if (step_en) begin
      in_frame_r   <= in_frame_nxt;
      count_r      <= count_nxt;
      lost_r       <= lost_nxt;
      comma_seen_r <= comma_seen_nxt;
      comma_pos_r  <= comma_pos_nxt;
      x_acc_r      <= x_acc_nxt;
      x_neg_r      <= x_neg_nxt;
      x_end_r      <= x_end_nxt;
      y_acc_r      <= y_acc_nxt;
      y_neg_r      <= y_neg_nxt;
      y_end_r      <= y_end_nxt;
      frame_r      <= frame_nxt;
    end
  end

endmodule

### rtl/core/acfp_out_reg.sv
`timescale 1ns / 1ps

module acfp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  acfp_pkg::result_t res,
  output logic              can_take,
  output logic              out_tvalid,
  input  logic              out_tready,
  output acfp_pkg::result_t out_res
);
  import acfp_pkg::*;

  logic    valid_r;
  result_t data_r;

  // The register frees up in the same cycle its item is taken downstream.
  assign can_take   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      data_r <= res;
    end
  end

endmodule

### rtl/core/ascii_coordinate_frame_parser_core.sv
`timescale 1ns / 1ps

// ASCII coordinate frame parser.
// The input channel takes one received byte per item on in_tdata. Bytes are
// dropped until a '$' opens a frame; the body then runs to CR or LF. A body
// starting with LOST yields a lost item, a body of the form x,y yields the
// two parsed coordinates, and anything else closes silently. Each result
// item carries the coordinates and a wrapping 16-bit frame number on
// out_tdata and the lost flag on out_tuser.
// Throughput is one byte per cycle: every byte is parsed by the single
// stage of logic between the parser state registers and the output
// register. A result item appears on out_tvalid in the cycle after its
// terminating byte is accepted.
// While a result waits in the output register and out_tready is low,
// in_tready is low too, so no byte is taken until the result drains.
// Synchronous reset returns the parser to hunting for '$', clears the frame
// number and empties the output register.

module ascii_coordinate_frame_parser_core #(
  parameter int unsigned BODY_BUFFER_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] x_value, [31:16] y_value, [47:32] frame_number
  output logic        out_tuser   // [0] target_lost
);
  import acfp_pkg::*;

  logic    step_en;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign step_en = in_tvalid && in_tready;

  acfp_parser #(
    .BODY_BUFFER_SIZE(BODY_BUFFER_SIZE)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .rx_byte  (in_tdata),
    .res_valid(res_valid),
    .res      (res)
  );

  acfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.frame_number, out_res.y_value, out_res.x_value};
  assign out_tuser = out_res.target_lost;

endmodule

### rtl/core/acfp_checker.sv
`timescale 1ns / 1ps

module acfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result item holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  // A lost item carries zero coordinates.
  a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[31:0] == 32'd0)
    else $error("lost item with non-zero coordinates");

  // No byte is taken while a result is held back by the receiver.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("byte accepted while output register full");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item visible after reset");

  // A result only follows an accepted byte.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid ##1 out_tvalid |-> $past(in_tvalid && in_tready))
    else $error("result item without an accepted byte");

endmodule

bind ascii_coordinate_frame_parser_core acfp_checker u_acfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
